// ===== rtl/lma_pkg.sv =====
// ----------------------------------------------------------------------------
// lma_pkg
// Shared types and constants for the nearest landmark association block.
// ----------------------------------------------------------------------------
package lma_pkg;

   localparam int MAX_LANDMARKS = 64;
   localparam int IDX_W         = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
   localparam int CNT_W         = $clog2(MAX_LANDMARKS + 1);
   localparam int COORD_W       = 32;
   localparam int ID_W          = 16;
   localparam int SQ_W          = 2 * COORD_W;
   localparam int DIST_W        = SQ_W + 1;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]                opcode;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [ID_W-1:0]           landmark_id;
   } lma_req_type;

   typedef struct packed {
      logic            match_found;
      logic [ID_W-1:0] match_id;
   } lma_rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [ID_W-1:0]           id;
   } lma_entry_type;

   typedef struct packed {
      logic query_load;
      logic rd_en;
   } lma_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_DRAIN,
      ST_RESP
   } lma_state_type;

endpackage

// ===== rtl/lma_table.sv =====
// ----------------------------------------------------------------------------
// lma_table
// Landmark storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lma_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [lma_pkg::IDX_W-1:0]  wr_addr,
   input  lma_pkg::lma_entry_type     wr_data,
   input  logic                       rd_en,
   input  logic [lma_pkg::IDX_W-1:0]  rd_addr,
   output lma_pkg::lma_entry_type     rd_data
);
   import lma_pkg::*;

   lma_entry_type mem [MAX_LANDMARKS];
   lma_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lma_datapath.sv =====
// ----------------------------------------------------------------------------
// lma_datapath
// Distance pipeline around one shared 32x32 squarer, plus best tracking.
// ----------------------------------------------------------------------------
module lma_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lma_pkg::lma_ctl_type         ctl,
   input  logic signed [lma_pkg::COORD_W-1:0] obs_x,
   input  logic signed [lma_pkg::COORD_W-1:0] obs_y,
   input  lma_pkg::lma_entry_type       rd_data,
   output logic                         pipe_busy,
   output logic                         best_found,
   output logic [lma_pkg::ID_W-1:0]     best_id
);
   import lma_pkg::*;

   function automatic logic [COORD_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                   logic signed [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      logic [COORD_W:0] m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[COORD_W-1:0];
   endfunction

   logic signed [COORD_W-1:0] obs_x_ff, obs_x_in;
   logic signed [COORD_W-1:0] obs_y_ff, obs_y_in;
   logic                      s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic [SQ_W-1:0]           prod_ff, prod_in;
   logic [SQ_W-1:0]           sqx_ff, sqx_in;
   logic [COORD_W-1:0]        dy_ff, dy_in;
   logic [ID_W-1:0]           id1_ff, id1_in;
   logic [ID_W-1:0]           id2_ff, id2_in;
   logic [ID_W-1:0]           id3_ff, id3_in;
   logic [DIST_W-1:0]         sum_ff, sum_in;
   logic [DIST_W-1:0]         best_dist_ff, best_dist_in;
   logic                      best_found_ff, best_found_in;
   logic [ID_W-1:0]           best_id_ff, best_id_in;

   logic [COORD_W-1:0]        dx;
   logic [COORD_W-1:0]        mul_a;
   logic [SQ_W-1:0]           mul_p;

   assign dx    = abs_diff(obs_x_ff, rd_data.x);
   assign mul_a = s1_v_ff ? dx : dy_ff;
   assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_a);

   always_comb begin
      obs_x_in      = obs_x_ff;
      obs_y_in      = obs_y_ff;
      prod_in       = prod_ff;
      sqx_in        = sqx_ff;
      dy_in         = dy_ff;
      id1_in        = id1_ff;
      id2_in        = id2_ff;
      id3_in        = id3_ff;
      sum_in        = sum_ff;
      best_dist_in  = best_dist_ff;
      best_found_in = best_found_ff;
      best_id_in    = best_id_ff;

      // stage 1: x square, latch y magnitude
      if (s1_v_ff) begin
         prod_in = mul_p;
         dy_in   = abs_diff(obs_y_ff, rd_data.y);
         id1_in  = rd_data.id;
      end
      // stage 2: y square
      if (s2_v_ff) begin
         prod_in = mul_p;
         sqx_in  = prod_ff;
         id2_in  = id1_ff;
      end
      // stage 3: sum of squares
      if (s3_v_ff) begin
         sum_in = {1'b0, sqx_ff} + {1'b0, prod_ff};
         id3_in = id2_ff;
      end
      // stage 4: strict less keeps earliest on tie
      if (s4_v_ff && (!best_found_ff || (sum_ff < best_dist_ff))) begin
         best_found_in = 1'b1;
         best_dist_in  = sum_ff;
         best_id_in    = id3_ff;
      end
      if (ctl.query_load) begin
         obs_x_in      = obs_x;
         obs_y_in      = obs_y;
         best_found_in = 1'b0;
         best_id_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         s3_v_ff       <= 1'b0;
         s4_v_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         best_id_ff    <= '0;
      end else begin
         s1_v_ff       <= ctl.rd_en;
         s2_v_ff       <= s1_v_ff;
         s3_v_ff       <= s2_v_ff;
         s4_v_ff       <= s3_v_ff;
         best_found_ff <= best_found_in;
         best_id_ff    <= best_id_in;
      end
   end

   always_ff @(posedge clock) begin
      obs_x_ff     <= obs_x_in;
      obs_y_ff     <= obs_y_in;
      prod_ff      <= prod_in;
      sqx_ff       <= sqx_in;
      dy_ff        <= dy_in;
      id1_ff       <= id1_in;
      id2_ff       <= id2_in;
      id3_ff       <= id3_in;
      sum_ff       <= sum_in;
      best_dist_ff <= best_dist_in;
   end

   assign pipe_busy  = s1_v_ff | s2_v_ff | s3_v_ff | s4_v_ff;
   assign best_found = best_found_ff;
   assign best_id    = best_id_ff;

endmodule

// ===== rtl/lma_seq.sv =====
// ----------------------------------------------------------------------------
// lma_seq
// Request decode, entry count and table walk sequencer.
// ----------------------------------------------------------------------------
module lma_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  lma_pkg::lma_req_type       req,
   input  logic                       pipe_busy,
   output logic                       busy,
   output logic                       rsp_valid,
   output lma_pkg::lma_ctl_type       ctl,
   output logic                       wr_en,
   output logic [lma_pkg::IDX_W-1:0]  wr_addr,
   output logic [lma_pkg::IDX_W-1:0]  rd_addr
);
   import lma_pkg::*;

   lma_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] last;

   assign last = count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      ctl.query_load = 1'b0;
      ctl.rd_en      = 1'b0;
      wr_en          = 1'b0;
      busy           = (state_ff != ST_IDLE);
      rsp_valid      = (state_ff == ST_RESP);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(MAX_LANDMARKS)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     ctl.query_load = 1'b1;
                     idx_in         = '0;
                     state_in       = (count_ff == '0) ? ST_RESP : ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            ctl.rd_en = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (CNT_W'(idx_ff) == last) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign wr_addr = count_ff[IDX_W-1:0];
   assign rd_addr = idx_ff;

endmodule

// ===== rtl/nearest_landmark_association_top.sv =====
// ----------------------------------------------------------------------------
// nearest_landmark_association_top
// Landmark table with nearest neighbor query on squared distance.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. The
//   opcode clears the table, appends one landmark (dropped when full), or
//   queries with an observed x,y point.
//   Clear and append finish in the accept cycle and give no response; busy
//   stays low, so the next request may follow on the next cycle.
//   A query raises busy and walks the table through one shared 32x32 squarer
//   that takes x then y of each entry; each stored landmark is read in
//   ST_READ and then held in ST_WAIT. After the last entry the sequencer
//   waits in ST_DRAIN until the distance pipeline is empty, then strobes
//   rsp_valid (directly for an empty table); busy drops the cycle after.
//   rsp_valid is high for one cycle with match_found and match_id; the
//   receiver cannot stall, the response must be taken in that cycle.
//   On ties the earliest stored landmark wins.
//   Reset empties the table and returns the block to idle.
// ----------------------------------------------------------------------------
module nearest_landmark_association_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lma_pkg::lma_req_type  req,
   output logic                  rsp_valid,
   output lma_pkg::lma_rsp_type  rsp
);
   import lma_pkg::*;

   lma_ctl_type      ctl;
   logic             pipe_busy;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   lma_entry_type    wr_data;
   lma_entry_type    rd_data;
   logic             best_found;
   logic [ID_W-1:0]  best_id;

   assign wr_data.x  = req.point_x;
   assign wr_data.y  = req.point_y;
   assign wr_data.id = req.landmark_id;

   lma_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .pipe_busy (pipe_busy),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr)
   );

   lma_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lma_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .obs_x      (req.point_x),
      .obs_y      (req.point_y),
      .rd_data    (rd_data),
      .pipe_busy  (pipe_busy),
      .best_found (best_found),
      .best_id    (best_id)
   );

   assign rsp.match_found = best_found;
   assign rsp.match_id    = best_id;

   a_rsp_while_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside of a query");

   a_rsp_pipe_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !pipe_busy)
      else $error("response while distance pipeline still active");

   a_query_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req.opcode == OP_QUERY)) |=> busy)
      else $error("query accepted without raising busy");

   a_rsp_then_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("block not idle after response");

endmodule
